/* hw/rtl/salc_pkg.sv */
`default_nettype none

package salc_pkg;

    localparam int CACHE_BYTES_DEF = 8192;
    localparam int LINE_BYTES_DEF  = 64;
    localparam int WAYS_DEF        = 4;
    localparam int ADDR_BITS_DEF   = 48;

    localparam int ADDRESS_W  = 48;
    localparam int BYTES_W    = 8;
    localparam int PEN_W      = 16;
    localparam int CNT_W      = 32;
    localparam int SUM_W      = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 56;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 2 * CNT_W + 3 * SUM_W;
    localparam int OUT_USER_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_HIT_PENALTY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_PENALTY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WB_PENALTY   = 2'd2;

    localparam logic [PEN_W-1:0] HIT_PENALTY_RST  = 16'd1;
    localparam logic [PEN_W-1:0] MISS_PENALTY_RST = 16'd200;
    localparam logic [PEN_W-1:0] WB_PENALTY_RST   = 16'd50;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } t_state;

    typedef struct packed {
        logic                 en;
        logic [CFG_IDX_W-1:0] index;
        logic [PEN_W-1:0]     data;
    } t_cfg_wr;

    typedef struct packed {
        logic en;
        logic hit;
        logic wb;
    } t_stat_upd;

endpackage

`default_nettype wire

/* hw/rtl/salc_set_mem.sv */
`default_nettype none

module salc_set_mem #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5,
    parameter int WORD_W = 156
) (
    input  wire logic              i_clk,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WORD_W-1:0] o_rd_data,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WORD_W-1:0] i_wr_data
);

    logic [WORD_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/salc_way_logic.sv */
`default_nettype none

module salc_way_logic #(
    parameter int WAYS   = 4,
    parameter int TAG_W  = 35,
    parameter int RANK_W = 2
) (
    input  wire logic [WAYS-1:0][TAG_W-1:0]  i_tags,
    input  wire logic [WAYS-1:0][RANK_W-1:0] i_rank,
    input  wire logic [WAYS-1:0]             i_dirty,
    input  wire logic [WAYS-1:0]             i_valid,
    input  wire logic [TAG_W-1:0]            i_tag,
    input  wire logic                        i_write,
    output logic                             o_hit,
    output logic                             o_wb,
    output logic      [WAYS-1:0][TAG_W-1:0]  o_tags,
    output logic      [WAYS-1:0][RANK_W-1:0] o_rank,
    output logic      [WAYS-1:0]             o_dirty,
    output logic      [WAYS-1:0]             o_valid
);

    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

    logic              hit;
    logic [WAY_W-1:0]  hit_way;
    logic              has_inv;
    logic [WAY_W-1:0]  inv_way;
    logic [RANK_W-1:0] valid_cnt;
    logic [RANK_W-1:0] best;
    logic [WAY_W-1:0]  lru_way;
    logic [WAY_W-1:0]  sel_way;
    logic [RANK_W-1:0] old_rank;

    always_comb begin
        hit     = 1'b0;
        hit_way = '0;
        has_inv = 1'b0;
        inv_way = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (i_valid[i] && (i_tags[i] == i_tag)) begin
                hit     = 1'b1;
                hit_way = WAY_W'(i);
            end
            if (!i_valid[i]) begin
                has_inv = 1'b1;
                inv_way = WAY_W'(i);
            end
        end

        valid_cnt = RANK_W'($countones(i_valid));

        best    = '0;
        lru_way = '0;
        for (int i = 0; i < WAYS; i++) begin
            if (i_rank[i] >= best) begin
                best    = i_rank[i];
                lru_way = WAY_W'(i);
            end
        end

        if (hit) begin
            sel_way  = hit_way;
            old_rank = i_rank[hit_way];
        end else if (has_inv) begin
            sel_way  = inv_way;
            old_rank = valid_cnt;
        end else begin
            sel_way  = lru_way;
            old_rank = best;
        end

        for (int i = 0; i < WAYS; i++) begin
            o_tags[i]  = i_tags[i];
            o_rank[i]  = i_rank[i];
            o_dirty[i] = i_dirty[i];
            o_valid[i] = i_valid[i];
            if (WAY_W'(i) == sel_way) begin
                o_rank[i]  = '0;
                o_valid[i] = 1'b1;
                o_dirty[i] = hit ? (i_dirty[i] | i_write) : i_write;
                o_tags[i]  = hit ? i_tags[i] : i_tag;
            end else if (i_valid[i] && (i_rank[i] < old_rank)) begin
                o_rank[i] = i_rank[i] + RANK_W'(1);
            end
        end

        o_hit = hit;
        o_wb  = !hit && !has_inv && i_dirty[lru_way];
    end

endmodule

`default_nettype wire

/* hw/rtl/salc_stats.sv */
`default_nettype none

module salc_stats (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire salc_pkg::t_cfg_wr             i_cfg,
    input  wire salc_pkg::t_stat_upd           i_upd,
    output logic [salc_pkg::CNT_W-1:0]         o_hits,
    output logic [salc_pkg::CNT_W-1:0]         o_misses,
    output logic [salc_pkg::SUM_W-1:0]         o_hit_cycles,
    output logic [salc_pkg::SUM_W-1:0]         o_miss_cycles,
    output logic [salc_pkg::SUM_W-1:0]         o_total_cycles
);

    localparam int SUM_X = salc_pkg::SUM_W + 2;

    logic [salc_pkg::PEN_W-1:0] r_hit_pen;
    logic [salc_pkg::PEN_W-1:0] r_miss_pen;
    logic [salc_pkg::PEN_W-1:0] r_wb_pen;
    logic [salc_pkg::CNT_W-1:0] r_hits;
    logic [salc_pkg::CNT_W-1:0] r_misses;
    logic [salc_pkg::SUM_W-1:0] r_hit_cyc;
    logic [salc_pkg::SUM_W-1:0] r_miss_cyc;
    logic [salc_pkg::SUM_W-1:0] r_total;

    logic [salc_pkg::CNT_W-1:0] n_hits;
    logic [salc_pkg::CNT_W-1:0] n_misses;
    logic [salc_pkg::SUM_W-1:0] n_hit_cyc;
    logic [salc_pkg::SUM_W-1:0] n_miss_cyc;
    logic [salc_pkg::SUM_W-1:0] n_total;

    logic [SUM_X-1:0] hit_sum;
    logic [SUM_X-1:0] miss_sum;
    logic [SUM_X-1:0] total_hit_sum;
    logic [SUM_X-1:0] total_miss_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_pen  <= salc_pkg::HIT_PENALTY_RST;
            r_miss_pen <= salc_pkg::MISS_PENALTY_RST;
            r_wb_pen   <= salc_pkg::WB_PENALTY_RST;
        end else if (i_cfg.en) begin
            case (i_cfg.index)
                salc_pkg::CFG_HIT_PENALTY:  r_hit_pen  <= i_cfg.data;
                salc_pkg::CFG_MISS_PENALTY: r_miss_pen <= i_cfg.data;
                salc_pkg::CFG_WB_PENALTY:   r_wb_pen   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        hit_sum        = SUM_X'(r_hit_cyc) + SUM_X'(r_hit_pen);
        miss_sum       = SUM_X'(r_miss_cyc) + SUM_X'(r_miss_pen);
        total_hit_sum  = SUM_X'(r_total) + SUM_X'(r_hit_pen);
        total_miss_sum = SUM_X'(r_total) + SUM_X'(r_miss_pen)
                       + (i_upd.wb ? SUM_X'(r_wb_pen) : '0);

        n_hits     = r_hits;
        n_misses   = r_misses;
        n_hit_cyc  = r_hit_cyc;
        n_miss_cyc = r_miss_cyc;
        n_total    = r_total;

        if (i_upd.en) begin
            if (i_upd.hit) begin
                n_hits    = (r_hits == salc_pkg::CNT_MAX) ? r_hits
                                                          : r_hits + salc_pkg::CNT_W'(1);
                n_hit_cyc = (hit_sum[SUM_X-1:salc_pkg::SUM_W] != '0) ? salc_pkg::SUM_MAX
                                                         : hit_sum[salc_pkg::SUM_W-1:0];
                n_total   = (total_hit_sum[SUM_X-1:salc_pkg::SUM_W] != '0) ? salc_pkg::SUM_MAX
                                                         : total_hit_sum[salc_pkg::SUM_W-1:0];
            end else begin
                n_misses   = (r_misses == salc_pkg::CNT_MAX) ? r_misses
                                                             : r_misses + salc_pkg::CNT_W'(1);
                n_miss_cyc = (miss_sum[SUM_X-1:salc_pkg::SUM_W] != '0) ? salc_pkg::SUM_MAX
                                                         : miss_sum[salc_pkg::SUM_W-1:0];
                n_total    = (total_miss_sum[SUM_X-1:salc_pkg::SUM_W] != '0) ? salc_pkg::SUM_MAX
                                                         : total_miss_sum[salc_pkg::SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits     <= '0;
            r_misses   <= '0;
            r_hit_cyc  <= '0;
            r_miss_cyc <= '0;
            r_total    <= '0;
        end else begin
            r_hits     <= n_hits;
            r_misses   <= n_misses;
            r_hit_cyc  <= n_hit_cyc;
            r_miss_cyc <= n_miss_cyc;
            r_total    <= n_total;
        end
    end

    assign o_hits         = r_hits;
    assign o_misses       = r_misses;
    assign o_hit_cycles   = r_hit_cyc;
    assign o_miss_cycles  = r_miss_cyc;
    assign o_total_cycles = r_total;

endmodule

`default_nettype wire

/* hw/rtl/set_assoc_lru_cache_model_top.sv */
// Set-associative true-LRU write-back cache model with timing counters.
// Input stream: one beat per access. tuser[0] is the command (0 read,
// 1 write); tdata holds the address and the access byte count.
// Output stream: one beat per access. tuser flags hit, writeback and
// split error; tdata carries the saturating hit/miss counts and the
// hit, miss and total cycle sums after the access.
// Config channel: i_cfg_index 0..2 selects hit, miss and writeback
// penalty; always ready, write only while no access is in flight.
// Each access reads its set word from the tag memory in ST_IDLE, then in
// ST_LOOK updates hit/LRU/dirty state, writes the word back (not for a
// split access) and loads the result. A new access is accepted only once
// the last leaves ST_LOOK, as the set memory is read-modify-written once.
// Reset clears the counters and loads the default penalties, then a
// clearing pass writes one set per cycle over all NUM_SETS sets (32 with the
// default geometry), during which s_axis_tready stays low.
// A finished result sits in the output register; the next access is
// still accepted, and it waits in its update cycle while m_axis_tready
// is low and the output register is full.
`default_nettype none

module set_assoc_lru_cache_model_top #(
    parameter int CACHE_BYTES = salc_pkg::CACHE_BYTES_DEF,
    parameter int LINE_BYTES  = salc_pkg::LINE_BYTES_DEF,
    parameter int WAYS        = salc_pkg::WAYS_DEF,
    parameter int ADDR_BITS   = salc_pkg::ADDR_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [47:0] address, [55:48] access_bytes
    input  wire logic [salc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [0] command
    input  wire logic [salc_pkg::IN_USER_W-1:0]      s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [31:0] hits_so_far, [63:32] misses_so_far, [111:64] hit_cycles_so_far,
    // [159:112] miss_cycles_so_far, [207:160] total_cycles_so_far
    output logic      [salc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // [0] hit, [1] writeback, [2] split_error
    output logic      [salc_pkg::OUT_USER_W-1:0]     m_axis_tuser,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [salc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [salc_pkg::PEN_W-1:0]          i_cfg_data
);

    localparam int AW_IN       = salc_pkg::ADDRESS_W;
    localparam int BLOCK_BYTES = LINE_BYTES * WAYS;
    localparam int NUM_SETS    = ((CACHE_BYTES / BLOCK_BYTES) > 0)
                               ? (CACHE_BYTES / BLOCK_BYTES) : 1;
    localparam int OBITS       = $clog2(BLOCK_BYTES + 1) - 1;
    localparam int TBITS       = $clog2(CACHE_BYTES + 1) - 1;
    localparam int AW          = (ADDR_BITS < AW_IN) ? ADDR_BITS : AW_IN;
    localparam int TAG_W       = (AW > TBITS) ? (AW - TBITS) : 1;
    localparam int SET_W       = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int RANK_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WORD_W      = WAYS * (TAG_W + RANK_W + 2);
    localparam int CHK_W       = $clog2(BLOCK_BYTES + 256) + 1;

    localparam logic [AW_IN-1:0] AMASK = (ADDR_BITS >= AW_IN) ? {AW_IN{1'b1}}
                                       : AW_IN'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [AW_IN-1:0] BLK_MASK = AW_IN'(BLOCK_BYTES - 1);
    localparam logic [AW_IN-1:0] SET_MASK = AW_IN'(NUM_SETS - 1);
    localparam logic [SET_W-1:0] LAST_SET = SET_W'(NUM_SETS - 1);

    salc_pkg::t_state r_state;
    salc_pkg::t_state n_state;

    logic [SET_W-1:0] r_clr_idx;
    logic             r_cmd;
    logic [SET_W-1:0] r_set;
    logic [TAG_W-1:0] r_tag;
    logic             r_split;
    logic             r_out_valid;
    logic             r_hit;
    logic             r_wb;
    logic             r_split_out;

    logic [AW_IN-1:0]             in_addr;
    logic [salc_pkg::BYTES_W-1:0] in_bytes;
    logic [CHK_W-1:0]             in_off;
    logic                         in_split;
    logic [SET_W-1:0]             in_set;
    logic [TAG_W-1:0]             in_tag;
    logic                         in_fire;
    logic                         out_free;
    logic                         look_done;

    logic [WORD_W-1:0] rd_word;
    logic [WORD_W-1:0] upd_word;
    logic              wr_en;
    logic [SET_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;

    logic [WAYS-1:0][TAG_W-1:0]  rd_tags;
    logic [WAYS-1:0][RANK_W-1:0] rd_rank;
    logic [WAYS-1:0]             rd_dirty;
    logic [WAYS-1:0]             rd_valid;
    logic [WAYS-1:0][TAG_W-1:0]  up_tags;
    logic [WAYS-1:0][RANK_W-1:0] up_rank;
    logic [WAYS-1:0]             up_dirty;
    logic [WAYS-1:0]             up_valid;
    logic                        wl_hit;
    logic                        wl_wb;

    salc_pkg::t_cfg_wr   cfg_wr;
    salc_pkg::t_stat_upd stat_upd;

    logic [salc_pkg::CNT_W-1:0] st_hits;
    logic [salc_pkg::CNT_W-1:0] st_misses;
    logic [salc_pkg::SUM_W-1:0] st_hit_cyc;
    logic [salc_pkg::SUM_W-1:0] st_miss_cyc;
    logic [salc_pkg::SUM_W-1:0] st_total;

    assign in_addr  = s_axis_tdata[AW_IN-1:0] & AMASK;
    assign in_bytes = s_axis_tdata[AW_IN +: salc_pkg::BYTES_W];
    assign in_off   = CHK_W'(in_addr & BLK_MASK);
    assign in_split = (in_off + CHK_W'(in_bytes)) > CHK_W'(BLOCK_BYTES);
    assign in_set   = SET_W'((in_addr >> OBITS) & SET_MASK);
    assign in_tag   = TAG_W'(in_addr >> TBITS);

    assign s_axis_tready = (r_state == salc_pkg::ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign look_done     = (r_state == salc_pkg::ST_LOOK) && out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            salc_pkg::ST_CLEAR: begin
                if (r_clr_idx == LAST_SET) n_state = salc_pkg::ST_IDLE;
            end
            salc_pkg::ST_IDLE: begin
                if (s_axis_tvalid) n_state = salc_pkg::ST_LOOK;
            end
            salc_pkg::ST_LOOK: begin
                if (out_free) n_state = salc_pkg::ST_IDLE;
            end
            default: n_state = salc_pkg::ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= salc_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (r_state == salc_pkg::ST_CLEAR) begin
            r_clr_idx <= r_clr_idx + SET_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd   <= s_axis_tuser[0];
            r_set   <= in_set;
            r_tag   <= in_tag;
            r_split <= in_split;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (look_done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (look_done) begin
            r_hit       <= !r_split && wl_hit;
            r_wb        <= !r_split && wl_wb;
            r_split_out <= r_split;
        end
    end

    assign {rd_tags, rd_rank, rd_dirty, rd_valid} = rd_word;
    assign upd_word = {up_tags, up_rank, up_dirty, up_valid};

    assign wr_en   = (r_state == salc_pkg::ST_CLEAR) || (look_done && !r_split);
    assign wr_addr = (r_state == salc_pkg::ST_CLEAR) ? r_clr_idx : r_set;
    assign wr_data = (r_state == salc_pkg::ST_CLEAR) ? '0 : upd_word;

    salc_set_mem #(
        .DEPTH  (NUM_SETS),
        .ADDR_W (SET_W),
        .WORD_W (WORD_W)
    ) u_set_mem (
        .i_clk     (i_clk),
        .i_rd_en   (in_fire),
        .i_rd_addr (in_set),
        .o_rd_data (rd_word),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    salc_way_logic #(
        .WAYS   (WAYS),
        .TAG_W  (TAG_W),
        .RANK_W (RANK_W)
    ) u_way_logic (
        .i_tags  (rd_tags),
        .i_rank  (rd_rank),
        .i_dirty (rd_dirty),
        .i_valid (rd_valid),
        .i_tag   (r_tag),
        .i_write (r_cmd),
        .o_hit   (wl_hit),
        .o_wb    (wl_wb),
        .o_tags  (up_tags),
        .o_rank  (up_rank),
        .o_dirty (up_dirty),
        .o_valid (up_valid)
    );

    assign o_cfg_ready  = 1'b1;
    assign cfg_wr.en    = i_cfg_valid && o_cfg_ready;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.data  = i_cfg_data;

    assign stat_upd.en  = look_done && !r_split;
    assign stat_upd.hit = wl_hit;
    assign stat_upd.wb  = wl_wb;

    salc_stats u_stats (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg_wr),
        .i_upd          (stat_upd),
        .o_hits         (st_hits),
        .o_misses       (st_misses),
        .o_hit_cycles   (st_hit_cyc),
        .o_miss_cycles  (st_miss_cyc),
        .o_total_cycles (st_total)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = {r_split_out, r_wb, r_hit};
    assign m_axis_tdata  = {st_total, st_miss_cyc, st_hit_cyc, st_misses, st_hits};

endmodule

`default_nettype wire

/* sim/tb_set_assoc_lru_cache_model_top.sv */
`timescale 1ns / 1ps

module tb_set_assoc_lru_cache_model_top;
    import salc_pkg::*;

    localparam int BLOCK      = LINE_BYTES_DEF * WAYS_DEF;
    localparam int NUM_SETS   = (CACHE_BYTES_DEF / BLOCK) > 0 ? CACHE_BYTES_DEF / BLOCK : 1;
    localparam int NUM_LINES  = NUM_SETS * WAYS_DEF;
    localparam int OFF_W      = $clog2(BLOCK);
    localparam int SET_W      = $clog2(NUM_SETS);
    localparam int TAG_LSB    = $clog2(CACHE_BYTES_DEF);
    localparam int TAG_W      = ADDRESS_W - TAG_LSB;
    localparam int RANK_W     = WAYS_DEF > 1 ? $clog2(WAYS_DEF) : 1;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int N_PHASES     = 6;
    localparam int PHASE_ITEMS  = 150;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } t_cmd;

    typedef struct packed {
        logic             hit;
        logic             wb;
        logic             split;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] misses;
        logic [SUM_W-1:0] hit_cycles;
        logic [SUM_W-1:0] miss_cycles;
        logic [SUM_W-1:0] total_cycles;
    } t_access_result;

    class cache_scoreboard;
        logic [ADDRESS_W-1:0] tag_mem[NUM_LINES];
        bit                   line_vld[NUM_LINES];
        bit                   line_dirty[NUM_LINES];
        logic [RANK_W-1:0]    lru_rank[NUM_LINES];
        logic [CNT_W-1:0]     hit_cnt, miss_cnt;
        logic [SUM_W-1:0]     hit_sum, miss_sum, time_sum;
        logic [PEN_W-1:0]     hit_pen, miss_pen, wb_pen;
        t_access_result       expected_q[$];
        int errors, n_access, n_result, n_hit, n_miss, n_wb, n_split;

        function new();
            foreach (tag_mem[i]) begin
                tag_mem[i]    = '0;
                line_vld[i]   = 1'b0;
                line_dirty[i] = 1'b0;
                lru_rank[i]   = '0;
            end
            hit_cnt  = '0;
            miss_cnt = '0;
            hit_sum  = '0;
            miss_sum = '0;
            time_sum = '0;
            hit_pen  = HIT_PENALTY_RST;
            miss_pen = MISS_PENALTY_RST;
            wb_pen   = WB_PENALTY_RST;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void set_penalty(logic [CFG_IDX_W-1:0] idx, logic [PEN_W-1:0] data);
            case (idx)
                CFG_HIT_PENALTY:  hit_pen  = data;
                CFG_MISS_PENALTY: miss_pen = data;
                CFG_WB_PENALTY:   wb_pen   = data;
                default: ;
            endcase
        endfunction

        function logic [CNT_W-1:0] cnt_inc(logic [CNT_W-1:0] a);
            return (a == CNT_MAX) ? a : a + 1'b1;
        endfunction

        function logic [SUM_W-1:0] sum_add(logic [SUM_W-1:0] a, logic [PEN_W-1:0] b);
            logic [SUM_W:0] s;
            s = {1'b0, a} + (SUM_W+1)'(b);
            return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
        endfunction

        // way w becomes most recent; younger valid ways age by one
        function void promote(int base, int w, int old_rank);
            for (int i = 0; i < WAYS_DEF; i++) begin
                if (i != w && line_vld[base+i] && int'(lru_rank[base+i]) < old_rank)
                    lru_rank[base+i] = lru_rank[base+i] + 1'b1;
            end
            lru_rank[base+w] = '0;
        endfunction

        function void note_access(t_cmd cmd, logic [ADDRESS_W-1:0] addr,
                                  logic [BYTES_W-1:0] nbytes);
            t_access_result       r;
            logic [OFF_W:0]       reach;
            logic [ADDRESS_W-1:0] tag;
            int base, way, victim, nvalid, old_rank, best;
            r = '0;
            n_access++;
            reach = {1'b0, addr[OFF_W-1:0]} + (OFF_W+1)'(nbytes);
            if (reach > BLOCK) begin
                r.split = 1'b1;
                n_split++;
            end else begin
                base = int'((addr >> OFF_W) & (NUM_SETS - 1)) * WAYS_DEF;
                tag  = addr >> TAG_LSB;
                way  = -1;
                for (int i = 0; i < WAYS_DEF; i++) begin
                    if (way < 0 && line_vld[base+i] && tag_mem[base+i] == tag)
                        way = i;
                end
                if (way >= 0) begin
                    r.hit = 1'b1;
                    n_hit++;
                    promote(base, way, int'(lru_rank[base+way]));
                    if (cmd == CMD_WRITE)
                        line_dirty[base+way] = 1'b1;
                    hit_cnt  = cnt_inc(hit_cnt);
                    hit_sum  = sum_add(hit_sum, hit_pen);
                    time_sum = sum_add(time_sum, hit_pen);
                end else begin
                    nvalid = 0;
                    victim = -1;
                    for (int i = 0; i < WAYS_DEF; i++) begin
                        if (line_vld[base+i])
                            nvalid++;
                        else if (victim < 0)
                            victim = i;
                    end
                    if (victim >= 0) begin
                        old_rank = nvalid;
                    end else begin
                        best   = 0;
                        victim = 0;
                        for (int i = 0; i < WAYS_DEF; i++) begin
                            if (int'(lru_rank[base+i]) >= best) begin
                                best   = int'(lru_rank[base+i]);
                                victim = i;
                            end
                        end
                        old_rank = best;
                        r.wb     = line_dirty[base+victim];
                    end
                    promote(base, victim, old_rank);
                    line_vld[base+victim]   = 1'b1;
                    line_dirty[base+victim] = (cmd == CMD_WRITE);
                    tag_mem[base+victim]    = tag;
                    n_miss++;
                    miss_cnt = cnt_inc(miss_cnt);
                    miss_sum = sum_add(miss_sum, miss_pen);
                    time_sum = sum_add(time_sum, miss_pen);
                    if (r.wb) begin
                        time_sum = sum_add(time_sum, wb_pen);
                        n_wb++;
                    end
                end
            end
            r.hits         = hit_cnt;
            r.misses       = miss_cnt;
            r.hit_cycles   = hit_sum;
            r.miss_cycles  = miss_sum;
            r.total_cycles = time_sum;
            expected_q.insert(expected_q.size(), r);
        endfunction

        task report(string msg);
            $display("MISMATCH %s", msg);
            errors++;
        endtask

        task cmp(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report($sformatf("beat %0d %s: got 0x%0h, expected 0x%0h",
                                 n_result, name, got, want));
        endtask

        task check_result(logic [OUT_USER_W-1:0] user, logic [OUT_DATA_W-1:0] data);
            t_access_result want;
            n_result++;
            if (expected_q.size() == 0) begin
                report($sformatf("beat %0d arrived with no access pending", n_result));
                return;
            end
            want = expected_q.pop_front();
            cmp("hit", 64'(user[0]), 64'(want.hit));
            cmp("writeback", 64'(user[1]), 64'(want.wb));
            cmp("split_error", 64'(user[2]), 64'(want.split));
            cmp("hits_so_far", 64'(data[0 +: CNT_W]), 64'(want.hits));
            cmp("misses_so_far", 64'(data[CNT_W +: CNT_W]), 64'(want.misses));
            cmp("hit_cycles_so_far", 64'(data[2*CNT_W +: SUM_W]), 64'(want.hit_cycles));
            cmp("miss_cycles_so_far", 64'(data[2*CNT_W+SUM_W +: SUM_W]),
                64'(want.miss_cycles));
            cmp("total_cycles_so_far", 64'(data[2*CNT_W+2*SUM_W +: SUM_W]),
                64'(want.total_cycles));
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [PEN_W-1:0]      i_cfg_data = '0;

    cache_scoreboard sb;
    int              src_idle_pct = 0;
    int              snk_idle_pct = 0;
    int              quiet_cycles = 0;
    logic [TAG_W-1:0] tag_pool[6];
    logic [SET_W-1:0] hot_set[3];

    set_assoc_lru_cache_model_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    initial sb = new();

    // beat monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_access(t_cmd'(s_axis_tuser[0]), s_axis_tdata[0 +: ADDRESS_W],
                               s_axis_tdata[ADDRESS_W +: BYTES_W]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tuser, m_axis_tdata);
            if (i_cfg_valid && o_cfg_ready)
                sb.set_penalty(i_cfg_index, i_cfg_data);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // result side backpressure
    initial begin
        forever begin
            @(posedge i_clk);
            if (snk_idle_pct > 0 && $urandom_range(0, 99) < snk_idle_pct) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic logic [ADDRESS_W-1:0] mk_addr(logic [TAG_W-1:0] tag,
                                                     logic [SET_W-1:0] set_idx, int off);
        logic [31:0] o;
        o = off;
        return {tag, set_idx, o[OFF_W-1:0]};
    endfunction

    task automatic send_access(t_cmd cmd, logic [ADDRESS_W-1:0] addr,
                               logic [BYTES_W-1:0] nbytes);
        if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {nbytes, addr};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [PEN_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic program_penalties(logic [PEN_W-1:0] h, logic [PEN_W-1:0] m,
                                     logic [PEN_W-1:0] w, bit poke_unused);
        write_cfg(CFG_HIT_PENALTY, h);
        write_cfg(CFG_MISS_PENALTY, m);
        if (poke_unused)
            write_cfg(CFG_UNUSED, PEN_W'($urandom_range(0, 65535)));
        write_cfg(CFG_WB_PENALTY, w);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic run_directed();
        logic [TAG_W-1:0] t0, t1, t2, t3, t4, t5;
        logic [SET_W-1:0] s;
        t0 = '0;
        t1 = 1;
        t2 = '1;
        t3 = {TAG_W/2{2'b10}};
        t4 = ~t3;
        t5 = 35'h123_4567;
        s  = 5;
        send_access(CMD_READ,  mk_addr(t0, s, 0), 0);      // cold miss
        send_access(CMD_WRITE, mk_addr(t0, s, 255), 1);    // write hit at block end
        send_access(CMD_READ,  mk_addr(t0, s, 255), 2);    // crosses block
        send_access(CMD_READ,  mk_addr(t0, s, 2), 255);    // crosses block
        send_access(CMD_READ,  mk_addr(t0, s, 1), 255);    // ends exactly at block end
        send_access(CMD_WRITE, mk_addr(t1, s, 0), 255);
        send_access(CMD_WRITE, mk_addr(t2, s, 16), 8);
        send_access(CMD_READ,  mk_addr(t3, s, 64), 64);    // set now full
        send_access(CMD_READ,  mk_addr(t1, s, 0), 4);
        send_access(CMD_READ,  mk_addr(t4, s, 0), 4);      // evicts dirty LRU
        send_access(CMD_READ,  mk_addr(t0, s, 0), 4);      // evicts dirty again
        send_access(CMD_READ,  mk_addr(t5, s, 0), 4);      // evicts clean line
        send_access(CMD_WRITE, mk_addr(t2, s, 128), 128);
        send_access(CMD_READ,  mk_addr(t1, s, 200), 56);
        send_access(CMD_READ,  '1, 0);                     // top of address space
        send_access(CMD_WRITE, '1, 1);
        send_access(CMD_READ,  '1, 255);
        send_access(CMD_WRITE, '0, 255);
        send_access(CMD_READ,  '0, 0);
        send_access(CMD_READ,  mk_addr(t2, s, 0), 0);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic new_working_set(bit edge_tags);
        logic [63:0] rnd;
        for (int i = 0; i < 6; i++) begin
            rnd = {$urandom, $urandom};
            tag_pool[i] = rnd[TAG_W-1:0];
        end
        if (edge_tags) begin
            tag_pool[0] = '0;
            tag_pool[1] = '1;
        end
        for (int i = 0; i < 3; i++)
            hot_set[i] = SET_W'($urandom_range(0, NUM_SETS - 1));
    endtask

    // mostly a small working set of tags over a few sets, some noise
    task automatic run_random(int n);
        logic [63:0]          rnd;
        logic [ADDRESS_W-1:0] addr;
        logic [BYTES_W-1:0]   nb;
        logic [SET_W-1:0]     set_idx;
        int                   roll, off;
        t_cmd                 cmd;
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(0, 99);
            cmd  = t_cmd'($urandom_range(0, 1));
            rnd  = {$urandom, $urandom};
            if (roll < 6) begin
                addr = rnd[ADDRESS_W-1:0];
                nb   = rnd[63 -: BYTES_W];
            end else begin
                off     = $urandom_range(0, BLOCK - 1);
                set_idx = (roll < 75) ? hot_set[$urandom_range(0, 2)]
                                      : rnd[SET_W-1:0];
                addr    = mk_addr(tag_pool[$urandom_range(0, 5)], set_idx, off);
                if (roll < 14)
                    nb = BYTES_W'($urandom_range(0, 255));
                else
                    nb = BYTES_W'($urandom_range(0, (BLOCK - off) > 255 ? 255
                                                                        : BLOCK - off));
            end
            send_access(cmd, addr, nb);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct = 15;
        snk_idle_pct = 10;
        run_directed();
        new_working_set(1'b1);
        run_random(PHASE_ITEMS - 20);

        for (int ph = 1; ph < N_PHASES; ph++) begin
            wait_drained();
            case (ph)
                1: begin
                    program_penalties(0, 0, 0, 1'b0);
                    src_idle_pct = 0;
                    snk_idle_pct = 25;
                end
                2: begin
                    program_penalties(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
                    src_idle_pct = 25;
                    snk_idle_pct = 0;
                end
                3: begin
                    program_penalties(PEN_W'($urandom_range(0, 65535)),
                                      PEN_W'($urandom_range(0, 65535)),
                                      PEN_W'($urandom_range(0, 65535)), 1'b1);
                    src_idle_pct = 10;
                    snk_idle_pct = 10;
                end
                4: begin
                    program_penalties(16'hFFFF, 0, 16'hFFFF, 1'b0);
                    src_idle_pct = 30;
                    snk_idle_pct = 30;
                end
                default: begin
                    program_penalties(PEN_W'($urandom_range(0, 65535)), 16'hFFFF,
                                      PEN_W'($urandom_range(0, 65535)), 1'b1);
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            new_working_set(ph % 2 == 0);
            run_random(PHASE_ITEMS);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d accesses over %0d penalty settings: %0d hits, %0d misses,",
                 sb.n_access, N_PHASES, sb.n_hit, sb.n_miss);
        $display("  %0d dirty evictions, %0d block-crossing rejects, %0d mismatches",
                 sb.n_wb, sb.n_split, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
